>>> hdl/gamep_pkg.sv
`timescale 1ns / 1ps

package gamep_pkg;

    // Field widths of the ports
    localparam int BYTE_DATA_W = 8;
    localparam int PIX_X_W     = 11;
    localparam int PIX_Y_W     = 12;
    localparam int ALPHA_W     = 8;
    localparam int GLYPH_W     = 17;
    localparam int SIDE_W      = 10;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_WIDE_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_WIDTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_HEIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NARROW_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NARROW_HEIGHT = 3'd4;

    localparam logic [GLYPH_W-1:0] RST_WIDE_COUNT    = 17'd1;
    localparam logic [SIDE_W-1:0]  RST_WIDE_WIDTH    = 10'd16;
    localparam logic [SIDE_W-1:0]  RST_WIDE_HEIGHT   = 10'd16;
    localparam logic [SIDE_W-1:0]  RST_NARROW_WIDTH  = 10'd8;
    localparam logic [SIDE_W-1:0]  RST_NARROW_HEIGHT = 10'd16;

    localparam int WIDE_COUNT_LIMIT = 65536;

    // One lane per bit of a bitmap byte
    localparam int LANES      = 8;
    localparam int LANE_IDX_W = 3;

    localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'd255;

    // One accepted byte with its placement, shared by all lanes
    typedef struct packed {
        logic [PIX_X_W-1:0]     px_base;
        logic [PIX_Y_W-1:0]     py;
        logic [GLYPH_W-1:0]     glyph;
        logic                   wide;
        logic [PIX_X_W-1:0]     ox;
        logic [PIX_Y_W-1:0]     oy;
        logic                   err;
        logic [BYTE_DATA_W-1:0] bits;
        logic [LANE_IDX_W-1:0]  last_idx;
    } bundle_t;

    // One pixel write
    typedef struct packed {
        logic [PIX_X_W-1:0] pixel_x;
        logic [PIX_Y_W-1:0] pixel_y;
        logic               red;
        logic [ALPHA_W-1:0] alpha;
        logic [GLYPH_W-1:0] glyph;
        logic               wide;
        logic [PIX_X_W-1:0] ox;
        logic [PIX_Y_W-1:0] oy;
        logic               err;
        logic               last;
    } result_t;

    // Layout checker status
    typedef struct packed {
        logic busy;
        logic ok;
    } lay_stat_t;

endpackage

>>> hdl/gamep_layout.sv
`timescale 1ns / 1ps

module gamep_layout #(
    parameter int ATLAS_WIDTH      = 2048,
    parameter int MAX_ATLAS_HEIGHT = 4096,
    parameter int NARROW_GLYPHS    = 256,
    parameter int MAX_GLYPH_SIDE   = 512
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [gamep_pkg::GLYPH_W-1:0]      wide_count,
    input  logic [gamep_pkg::SIDE_W-1:0]       wide_width,
    input  logic [gamep_pkg::SIDE_W-1:0]       wide_height,
    input  logic [gamep_pkg::SIDE_W-1:0]       narrow_width,
    input  logic [gamep_pkg::SIDE_W-1:0]       narrow_height,
    output gamep_pkg::lay_stat_t               stat,
    output logic [$clog2(MAX_ATLAS_HEIGHT):0]  narrow_top
);
    import gamep_pkg::*;

    localparam int YW     = $clog2(MAX_ATLAS_HEIGHT) + 1;
    localparam int DIV_W  = $clog2(WIDE_COUNT_LIMIT + ATLAS_WIDTH);
    localparam int STEP_W = $clog2(DIV_W);
    localparam int PW     = DIV_W + SIDE_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_MUL_W = 3'd2;
    localparam logic [2:0] ST_MUL_N = 3'd3;
    localparam logic [2:0] ST_CHECK = 3'd4;

    localparam logic [1:0] PH_WIDE_PER_ROW   = 2'd0;
    localparam logic [1:0] PH_WIDE_ROWS      = 2'd1;
    localparam logic [1:0] PH_NARROW_PER_ROW = 2'd2;
    localparam logic [1:0] PH_NARROW_ROWS    = 2'd3;

    logic [2:0]        state_reg;
    logic [1:0]        phase_reg;
    logic              ok_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [DIV_W-1:0]  dvs_reg;
    logic [DIV_W-1:0]  wrows_reg;
    logic [DIV_W-1:0]  nrows_reg;
    logic [PW-1:0]     prod_w_reg;
    logic [PW-1:0]     prod_n_reg;
    logic [YW-1:0]     top_reg;

    logic              sides_ok;
    logic [DIV_W:0]    trial;
    logic              ge;
    logic [DIV_W-1:0]  rem_step;
    logic [DIV_W-1:0]  q;
    logic              div_last;
    logic              div_load;
    logic              fail;
    logic [DIV_W-1:0]  ld_dividend;
    logic [DIV_W-1:0]  ld_divisor;
    logic [PW:0]       need;

    // Range checks that need no division
    assign sides_ok = (wide_count != '0) && (wide_count <= GLYPH_W'(WIDE_COUNT_LIMIT))
        && (wide_width != '0) && (wide_width <= SIDE_W'(MAX_GLYPH_SIDE))
        && (wide_height != '0) && (wide_height <= SIDE_W'(MAX_GLYPH_SIDE))
        && (narrow_width != '0) && (narrow_width <= SIDE_W'(MAX_GLYPH_SIDE))
        && (narrow_height != '0) && (narrow_height <= SIDE_W'(MAX_GLYPH_SIDE));

    // Restoring divider, one quotient bit per cycle
    assign trial    = {rem_reg, quo_reg[DIV_W-1]};
    assign ge       = trial >= {1'b0, dvs_reg};
    assign rem_step = ge ? DIV_W'(trial - {1'b0, dvs_reg}) : trial[DIV_W-1:0];
    assign q        = {quo_reg[DIV_W-2:0], ge};
    assign div_last = (state_reg == ST_DIV) && (step_reg == '0);

    assign need = (PW+1)'(prod_w_reg) + (PW+1)'(prod_n_reg);

    // Pick the next division of the sequence
    always_comb
    begin
        div_load    = 1'b0;
        fail        = 1'b0;
        ld_dividend = DIV_W'(ATLAS_WIDTH);
        ld_divisor  = DIV_W'(wide_width);
        if (start)
        begin
            div_load = sides_ok;
        end
        else if (div_last)
        begin
            case (phase_reg)
                PH_WIDE_PER_ROW:
                begin
                    fail        = (q == '0);
                    div_load    = (q != '0);
                    ld_dividend = DIV_W'(wide_count) + q - DIV_W'(1);
                    ld_divisor  = q;
                end
                PH_WIDE_ROWS:
                begin
                    div_load    = 1'b1;
                    ld_dividend = DIV_W'(ATLAS_WIDTH);
                    ld_divisor  = DIV_W'(narrow_width);
                end
                PH_NARROW_PER_ROW:
                begin
                    fail        = (q == '0);
                    div_load    = (q != '0);
                    ld_dividend = DIV_W'(NARROW_GLYPHS) + q - DIV_W'(1);
                    ld_divisor  = q;
                end
                default:
                begin
                    div_load = 1'b0;
                end
            endcase
        end
    end

    // Sequence the check
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_WIDE_PER_ROW;
            ok_reg    <= 1'b0;
        end
        else if (start)
        begin
            ok_reg    <= 1'b0;
            phase_reg <= PH_WIDE_PER_ROW;
            state_reg <= sides_ok ? ST_DIV : ST_IDLE;
        end
        else
        begin
            case (state_reg)
                ST_DIV:
                begin
                    if (div_last)
                    begin
                        if (fail)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else if (phase_reg == PH_NARROW_ROWS)
                        begin
                            state_reg <= ST_MUL_W;
                        end
                        else
                        begin
                            phase_reg <= phase_reg + 2'd1;
                        end
                    end
                end
                ST_MUL_W:
                begin
                    state_reg <= ST_MUL_N;
                end
                ST_MUL_N:
                begin
                    state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    ok_reg    <= need <= (PW+1)'(MAX_ATLAS_HEIGHT);
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Divider and product datapath
    always_ff @(posedge clk)
    begin
        if (div_load)
        begin
            rem_reg  <= '0;
            quo_reg  <= ld_dividend;
            dvs_reg  <= ld_divisor;
            step_reg <= STEP_W'(DIV_W - 1);
        end
        else if (state_reg == ST_DIV)
        begin
            rem_reg  <= rem_step;
            quo_reg  <= q;
            step_reg <= step_reg - STEP_W'(1);
        end
        if (div_last && (phase_reg == PH_WIDE_ROWS))
        begin
            wrows_reg <= q;
        end
        if (div_last && (phase_reg == PH_NARROW_ROWS))
        begin
            nrows_reg <= q;
        end
        if (state_reg == ST_MUL_W)
        begin
            prod_w_reg <= PW'(wrows_reg * wide_height);
        end
        if (state_reg == ST_MUL_N)
        begin
            prod_n_reg <= PW'(nrows_reg * narrow_height);
        end
        if (state_reg == ST_CHECK)
        begin
            top_reg <= YW'(prod_w_reg);
        end
    end

    assign stat.busy  = start || (state_reg != ST_IDLE);
    assign stat.ok    = ok_reg;
    assign narrow_top = top_reg;

endmodule

>>> hdl/gamep_lane.sv
`timescale 1ns / 1ps

module gamep_lane (
    input  gamep_pkg::bundle_t                 bun,
    input  logic [gamep_pkg::LANE_IDX_W-1:0]   lane_idx,
    output gamep_pkg::result_t                 res
);
    import gamep_pkg::*;

    logic [BYTE_DATA_W-1:0] bit_sel;
    logic                   fg;

    // Bit 7 is the leftmost pixel
    assign bit_sel = bun.bits >> (LANE_IDX_W'(BYTE_DATA_W - 1) - lane_idx);
    assign fg      = bit_sel[0];

    // Expand one bit, or flag the layout error with last set and every other field zero
    always_comb
    begin
        if (bun.err)
        begin
            res      = '0;
            res.err  = 1'b1;
            res.last = 1'b1;
        end
        else
        begin
            res.pixel_x = bun.px_base + PIX_X_W'(lane_idx);
            res.pixel_y = bun.py;
            res.red     = fg;
            res.alpha   = fg ? ALPHA_OPAQUE : '0;
            res.glyph   = bun.glyph;
            res.wide    = bun.wide;
            res.ox      = bun.ox;
            res.oy      = bun.oy;
            res.err     = 1'b0;
            res.last    = (lane_idx == bun.last_idx);
        end
    end

endmodule

>>> hdl/gamep_merge.sv
`timescale 1ns / 1ps

module gamep_merge (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               bun_valid,
    input  logic [gamep_pkg::LANE_IDX_W-1:0]   last_idx,
    input  gamep_pkg::result_t                 lane_res [gamep_pkg::LANES],
    input  logic                               out_stall,
    output logic                               out_valid,
    output gamep_pkg::result_t                 res,
    output logic                               bun_done
);
    import gamep_pkg::*;

    logic [LANE_IDX_W-1:0] idx_reg;
    logic                  valid_reg;
    result_t               res_reg;
    logic                  load;

    // Take the next lane whenever the output register is free or draining
    assign load     = bun_valid && (!valid_reg || !out_stall);
    assign bun_done = load && (idx_reg == last_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= bun_done ? '0 : idx_reg + LANE_IDX_W'(1);
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Hold the result until its transfer
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= lane_res[idx_reg];
        end
    end

    assign out_valid = valid_reg;
    assign res       = res_reg;

endmodule

>>> hdl/glyph_atlas_mono_expand_packer_top.sv
`timescale 1ns / 1ps
// The first pixel write of a byte passes through the bundle register and then the output register.
// One pixel write per cycle while out_stall is low; a byte gives as many writes as it has
// pixels (1 to 8, 8 for a full byte); eight bit lanes feed one output register.
// Reset clears the packing state and loads the default registers; the layout check
// then runs (up to four 17-step serial divisions, then two multiplies),
// and again after each register write, with in_stall high meanwhile.
module glyph_atlas_mono_expand_packer_top #(
    parameter int ATLAS_WIDTH      = 2048,
    parameter int MAX_ATLAS_HEIGHT = 4096,
    parameter int NARROW_GLYPHS    = 256,
    parameter int MAX_GLYPH_SIDE   = 512
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [gamep_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gamep_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [gamep_pkg::BYTE_DATA_W-1:0]    bitmap_byte,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [gamep_pkg::PIX_X_W-1:0]        pixel_x,
    output logic [gamep_pkg::PIX_Y_W-1:0]        pixel_y,
    output logic                                 red_value,
    output logic [gamep_pkg::ALPHA_W-1:0]        alpha_value,
    output logic [gamep_pkg::GLYPH_W-1:0]        glyph_number,
    output logic                                 is_wide,
    output logic [gamep_pkg::PIX_X_W-1:0]        origin_x,
    output logic [gamep_pkg::PIX_Y_W-1:0]        origin_y,
    output logic                                 layout_error,
    output logic                                 last_of_byte
);
    import gamep_pkg::*;

    localparam int XW     = $clog2(ATLAS_WIDTH) + 1;
    localparam int YW     = $clog2(MAX_ATLAS_HEIGHT) + 1;
    localparam int ROW_W  = $clog2(MAX_GLYPH_SIDE);
    localparam int BYTE_W = $clog2((MAX_GLYPH_SIDE + 7) / 8 + 1);
    localparam int BASE_W = BYTE_W + 3;

    // Configuration registers
    logic [GLYPH_W-1:0] wide_count_reg;
    logic [SIDE_W-1:0]  wide_width_reg;
    logic [SIDE_W-1:0]  wide_height_reg;
    logic [SIDE_W-1:0]  narrow_width_reg;
    logic [SIDE_W-1:0]  narrow_height_reg;
    logic               start_reg;

    // Packing state
    logic [XW-1:0]      cx_reg;
    logic [YW-1:0]      cy_reg;
    logic [GLYPH_W-1:0] glyph_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [BYTE_W-1:0]  byte_reg;
    logic               narrow_reg;

    logic               bun_valid_reg;
    bundle_t            bun_reg;

    lay_stat_t          lay_stat;
    logic [YW-1:0]      narrow_top;
    logic               cfg_hit;
    logic               in_xfer;
    logic               bun_done;

    logic [SIDE_W-1:0]  w;
    logic [SIDE_W-1:0]  h;
    logic [SIDE_W-1:0]  bpr;
    logic               wrap;
    logic [XW-1:0]      cx_eff;
    logic [YW-1:0]      cy_eff;
    logic [BASE_W-1:0]  base;
    logic [SIDE_W:0]    rem;
    logic [LANE_IDX_W-1:0] last_idx;
    logic [XW:0]        x0;
    logic [YW-1:0]      y0;
    logic               byte_last;
    logic               row_last;
    logic [GLYPH_W:0]   glyph_inc;
    logic               wide_end;
    logic               pack_end;
    bundle_t            bun_next;

    result_t            lane_res [LANES];
    result_t            res;

    assign cfg_hit = cfg_write && (cfg_index == REG_WIDE_COUNT || cfg_index == REG_WIDE_WIDTH
        || cfg_index == REG_WIDE_HEIGHT || cfg_index == REG_NARROW_WIDTH
        || cfg_index == REG_NARROW_HEIGHT);

    assign in_stall = lay_stat.busy || cfg_write || (bun_valid_reg && !bun_done);
    assign in_xfer  = in_valid && !in_stall;

    // Sizes of the current phase
    assign w   = narrow_reg ? narrow_width_reg : wide_width_reg;
    assign h   = narrow_reg ? narrow_height_reg : wide_height_reg;
    assign bpr = (w + SIDE_W'(7)) >> 3;

    // Wrap to the next glyph row before the first byte of a glyph
    assign wrap   = (row_reg == '0) && (byte_reg == '0)
        && ((XW+1)'(cx_reg) + (XW+1)'(w) > (XW+1)'(ATLAS_WIDTH));
    assign cx_eff = wrap ? '0 : cx_reg;
    assign cy_eff = wrap ? YW'(cy_reg + YW'(h)) : cy_reg;

    // Pixels of this byte that lie inside the glyph
    assign base = {byte_reg, 3'b000};
    assign rem  = (SIDE_W+1)'(w) - (SIDE_W+1)'(base);
    always_comb
    begin
        if ((SIDE_W+1)'(base) >= (SIDE_W+1)'(w))
        begin
            last_idx = '0;
        end
        else if (rem >= (SIDE_W+1)'(LANES))
        begin
            last_idx = LANE_IDX_W'(LANES - 1);
        end
        else
        begin
            last_idx = LANE_IDX_W'(rem - (SIDE_W+1)'(1));
        end
    end

    assign x0 = (XW+1)'(cx_eff) + (XW+1)'(base);
    assign y0 = cy_eff + YW'(row_reg);

    assign byte_last = (SIDE_W'(byte_reg) + SIDE_W'(1)) >= bpr;
    assign row_last  = ((SIDE_W+1)'(row_reg) + (SIDE_W+1)'(1)) >= (SIDE_W+1)'(h);
    assign glyph_inc = (GLYPH_W+1)'(glyph_reg) + (GLYPH_W+1)'(1);
    assign wide_end  = !narrow_reg && (glyph_inc >= (GLYPH_W+1)'(wide_count_reg));
    assign pack_end  = narrow_reg && (glyph_inc >= (GLYPH_W+1)'(wide_count_reg)
        + (GLYPH_W+1)'(NARROW_GLYPHS));

    // Assemble the byte's bundle for the lanes
    always_comb
    begin
        bun_next = '0;
        if (!lay_stat.ok)
        begin
            bun_next.err = 1'b1;
        end
        else
        begin
            bun_next.px_base  = PIX_X_W'(x0);
            bun_next.py       = PIX_Y_W'(y0);
            bun_next.glyph    = glyph_reg;
            bun_next.wide     = !narrow_reg;
            bun_next.ox       = PIX_X_W'(cx_eff);
            bun_next.oy       = PIX_Y_W'(cy_eff);
            bun_next.bits     = bitmap_byte;
            bun_next.last_idx = last_idx;
        end
    end

    // Write configuration and restart the check
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_count_reg    <= RST_WIDE_COUNT;
            wide_width_reg    <= RST_WIDE_WIDTH;
            wide_height_reg   <= RST_WIDE_HEIGHT;
            narrow_width_reg  <= RST_NARROW_WIDTH;
            narrow_height_reg <= RST_NARROW_HEIGHT;
            start_reg         <= 1'b1;
        end
        else
        begin
            start_reg <= cfg_hit;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_WIDE_COUNT:    wide_count_reg    <= cfg_data;
                    REG_WIDE_WIDTH:    wide_width_reg    <= cfg_data[SIDE_W-1:0];
                    REG_WIDE_HEIGHT:   wide_height_reg   <= cfg_data[SIDE_W-1:0];
                    REG_NARROW_WIDTH:  narrow_width_reg  <= cfg_data[SIDE_W-1:0];
                    REG_NARROW_HEIGHT: narrow_height_reg <= cfg_data[SIDE_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    // Advance the placement cursor on each byte transfer while the layout is valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            glyph_reg  <= '0;
            row_reg    <= '0;
            byte_reg   <= '0;
            narrow_reg <= 1'b0;
        end
        else if (cfg_hit)
        begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            glyph_reg  <= '0;
            row_reg    <= '0;
            byte_reg   <= '0;
            narrow_reg <= 1'b0;
        end
        else if (in_xfer && lay_stat.ok)
        begin
            cx_reg <= cx_eff;
            cy_reg <= cy_eff;
            if (!byte_last)
            begin
                byte_reg <= byte_reg + BYTE_W'(1);
            end
            else
            begin
                byte_reg <= '0;
                if (!row_last)
                begin
                    row_reg <= row_reg + ROW_W'(1);
                end
                else
                begin
                    row_reg   <= '0;
                    cx_reg    <= XW'(cx_eff + XW'(w));
                    glyph_reg <= GLYPH_W'(glyph_inc);
                    if (wide_end)
                    begin
                        narrow_reg <= 1'b1;
                        cx_reg     <= '0;
                        cy_reg     <= narrow_top;
                    end
                    else if (pack_end)
                    begin
                        cx_reg     <= '0;
                        cy_reg     <= '0;
                        glyph_reg  <= '0;
                        narrow_reg <= 1'b0;
                    end
                end
            end
        end
    end

    // Hold the bundle until its last pixel moves to the output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bun_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            bun_valid_reg <= 1'b1;
        end
        else if (bun_done)
        begin
            bun_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            bun_reg <= bun_next;
        end
    end

    gamep_layout #(
        .ATLAS_WIDTH      (ATLAS_WIDTH),
        .MAX_ATLAS_HEIGHT (MAX_ATLAS_HEIGHT),
        .NARROW_GLYPHS    (NARROW_GLYPHS),
        .MAX_GLYPH_SIDE   (MAX_GLYPH_SIDE)
    ) u_layout (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start_reg),
        .wide_count    (wide_count_reg),
        .wide_width    (wide_width_reg),
        .wide_height   (wide_height_reg),
        .narrow_width  (narrow_width_reg),
        .narrow_height (narrow_height_reg),
        .stat          (lay_stat),
        .narrow_top    (narrow_top)
    );

    // One lane per bit of the byte
    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        gamep_lane u_lane (
            .bun      (bun_reg),
            .lane_idx (LANE_IDX_W'(i)),
            .res      (lane_res[i])
        );
    end

    gamep_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .bun_valid (bun_valid_reg),
        .last_idx  (bun_reg.last_idx),
        .lane_res  (lane_res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .res       (res),
        .bun_done  (bun_done)
    );

    assign pixel_x      = res.pixel_x;
    assign pixel_y      = res.pixel_y;
    assign red_value    = res.red;
    assign alpha_value  = res.alpha;
    assign glyph_number = res.glyph;
    assign is_wide      = res.wide;
    assign origin_x     = res.ox;
    assign origin_y     = res.oy;
    assign layout_error = res.err;
    assign last_of_byte = res.last;

endmodule
